// File: sv/wtsp_pkg.sv
// shared constants, codes and saturation helper for the world-to-screen projection unit
package wtsp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COEFF_WIDTH = 32;
    localparam int CW          = (COEFF_WIDTH < 32) ? COEFF_WIDTH : 32;
    localparam int MEM_DEPTH   = 32;
    localparam int MEM_AW      = 5;
    localparam int TERM_W      = 64 - FRAC_BITS;
    localparam int ACC_W       = TERM_W + 2;
    localparam int DVD_W       = 33 + FRAC_BITS;
    localparam int Q_W         = DVD_W + 1;

    localparam logic [1:0] CMD_LOAD_VIEW = 2'd0;
    localparam logic [1:0] CMD_LOAD_PROJ = 2'd1;
    localparam logic [1:0] CMD_PROJECT   = 2'd2;

    localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
    localparam logic [1:0] REG_WIN_TOP    = 2'd1;
    localparam logic [1:0] REG_WIN_WIDTH  = 2'd2;
    localparam logic [1:0] REG_WIN_HEIGHT = 2'd3;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/wtsp_div.sv
// radix-2 restoring divider, two dividends over one shared divisor, saturated quotients
module wtsp_div import wtsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num_x,
    input  logic signed [32:0] num_y,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [31:0] q_x,
    output logic signed [31:0] q_y
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dx_reg;
    logic [DVD_W-1:0] dy_reg;
    logic [33:0]      rx_reg;
    logic [33:0]      ry_reg;
    logic [32:0]      dmag_reg;
    logic             negx_reg;
    logic             negy_reg;

    logic [32:0]      absx;
    logic [32:0]      absy;
    logic [33:0]      absd;
    logic [33:0]      rx_sh;
    logic [33:0]      ry_sh;
    logic             gex;
    logic             gey;
    logic signed [Q_W-1:0] qx_mag;
    logic signed [Q_W-1:0] qy_mag;
    logic signed [Q_W-1:0] qx_s;
    logic signed [Q_W-1:0] qy_s;

    assign absx  = num_x[32] ? 33'(-num_x) : 33'(num_x);
    assign absy  = num_y[32] ? 33'(-num_y) : 33'(num_y);
    assign absd  = den[33] ? 34'(-den) : 34'(den);
    assign rx_sh = {rx_reg[32:0], dx_reg[DVD_W-1]};
    assign ry_sh = {ry_reg[32:0], dy_reg[DVD_W-1]};
    assign gex   = rx_sh >= {1'b0, dmag_reg};
    assign gey   = ry_sh >= {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dx_reg   <= DVD_W'(absx) << FRAC_BITS;
            dy_reg   <= DVD_W'(absy) << FRAC_BITS;
            rx_reg   <= '0;
            ry_reg   <= '0;
            dmag_reg <= absd[32:0];
            negx_reg <= num_x[32] ^ den[33];
            negy_reg <= num_y[32] ^ den[33];
        end else if (busy_reg) begin
            rx_reg <= gex ? rx_sh - {1'b0, dmag_reg} : rx_sh;
            ry_reg <= gey ? ry_sh - {1'b0, dmag_reg} : ry_sh;
            dx_reg <= {dx_reg[DVD_W-2:0], gex};
            dy_reg <= {dy_reg[DVD_W-2:0], gey};
        end
    end

    assign qx_mag = {1'b0, dx_reg};
    assign qy_mag = {1'b0, dy_reg};
    assign qx_s   = negx_reg ? -qx_mag : qx_mag;
    assign qy_s   = negy_reg ? -qy_mag : qy_mag;
    assign q_x    = sat32(64'(qx_s));
    assign q_y    = sat32(64'(qy_s));
    assign done   = done_reg;

endmodule

// File: sv/world_to_screen_projection_unit.sv
// top level: coefficient memory, shared multiply-accumulate sequencer, divider and scaling
//
// input channel (s_*): one beat per command. cmd 0 and 1 write one view or
// projection coefficient (column*4+row) and return nothing; cmd 2 projects a
// world point (w = 1) and returns one screen beat; cmd 3 is dropped.
// result channel (m_*): screen x/y in signed Q16.16 pixels, saturated, and
// w_zero when clip w was zero (x and y are then zero).
// window position and size are set over the APB port only while the unit is
// idle, a rule that the user must keep, since the block has no check for it.
// a project beat runs two passes of 16 products through one 32x32 multiplier
// fed from the coefficient memory (one read per cycle, then a pipeline drain),
// then the bit-serial divider, then two scaling multiplies and the output step.
// with zero clip w the divider and scaling are skipped.
// s_ready is high only between beats.
// the result register holds a finished beat while the receiver stalls; the
// next command is taken meanwhile, and a new result waits until it drains.
// reset clears both matrices to zero through per-entry valid bits, clears the
// window registers and drops m_valid.
module world_to_screen_projection_unit import wtsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [3:0]         s_coeff_index,
    input  logic signed [31:0] s_coeff_value,
    input  logic signed [31:0] s_world_x,
    input  logic signed [31:0] s_world_y,
    input  logic signed [31:0] s_world_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y,
    output logic               m_w_zero,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCLX  = 3'd4;
    localparam logic [2:0] ST_SCLY  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]         state_reg;
    logic               phase_reg;
    logic [3:0]         k_reg;
    logic [3:0]         k1_reg;
    logic [3:0]         k2_reg;
    logic               t1_v_reg;
    logic               t2_v_reg;

    logic signed [15:0] left_reg;
    logic signed [15:0] top_reg;
    logic [15:0]        width_reg;
    logic [15:0]        height_reg;

    logic [CW-1:0]        coef_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] coef_vld_reg;
    logic [CW-1:0]        rdata_reg;
    logic                 rvld_reg;

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;
    logic signed [31:0] vvec_reg [4];
    logic signed [31:0] cvec_reg [4];
    logic signed [31:0] pvec [4];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic               wz_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_sx_reg;
    logic signed [31:0] m_sy_reg;
    logic               m_wz_reg;

    logic               s_acc;
    logic               load_we;
    logic [MEM_AW-1:0]  wr_addr;
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;
    logic signed [31:0] coeff_ext;
    logic signed [31:0] vec_op;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [63:0] scl_x;
    logic signed [63:0] scl_y;
    logic               cfg_we;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_qx;
    logic signed [31:0] div_qy;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign load_we  = s_acc && (s_cmd == CMD_LOAD_VIEW || s_cmd == CMD_LOAD_PROJ);
    assign wr_addr  = {s_cmd == CMD_LOAD_PROJ, s_coeff_index};
    assign rd_en    = (state_reg == ST_ISSUE);
    assign rd_addr  = {phase_reg, k_reg[1:0], k_reg[3:2]};
    assign out_free = !m_valid_reg || m_ready;

    // coefficient memory, entries never written read as zero
    always_ff @(posedge aclk) begin
        if (load_we) begin
            coef_mem[wr_addr] <= s_coeff_value[CW-1:0];
        end
        if (rd_en) begin
            rdata_reg <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
            rvld_reg     <= 1'b0;
        end else begin
            if (load_we) begin
                coef_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= coef_vld_reg[rd_addr];
            end
        end
    end

    // apb registers
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_WIN_LEFT:   left_reg   <= pwdata[15:0];
                REG_WIN_TOP:    top_reg    <= pwdata[15:0];
                REG_WIN_WIDTH:  width_reg  <= pwdata[15:0];
                REG_WIN_HEIGHT: height_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIN_LEFT:   prdata = 32'(left_reg);
            REG_WIN_TOP:    prdata = 32'(top_reg);
            REG_WIN_WIDTH:  prdata = {16'd0, width_reg};
            REG_WIN_HEIGHT: prdata = {16'd0, height_reg};
            default:        prdata = '0;
        endcase
    end

    // multiply-accumulate datapath
    assign pvec[0]   = x_reg;
    assign pvec[1]   = y_reg;
    assign pvec[2]   = z_reg;
    assign pvec[3]   = 32'(1 << FRAC_BITS);
    assign coeff_ext = rvld_reg ? 32'($signed(rdata_reg)) : '0;
    assign vec_op    = phase_reg ? vvec_reg[k1_reg[1:0]] : pvec[k1_reg[1:0]];

    always_comb begin
        case (state_reg)
            ST_SCLX: begin
                mul_a = div_qx;
                mul_b = {16'd0, width_reg};
            end
            ST_SCLY: begin
                mul_a = div_qy;
                mul_b = {16'd0, height_reg};
            end
            default: begin
                mul_a = coeff_ext;
                mul_b = vec_op;
            end
        endcase
    end

    assign term    = prod_reg[63:FRAC_BITS];
    assign acc_sum = acc_reg + ACC_W'(term);
    assign scl_x   = prod_reg + (64'(left_reg) <<< FRAC_BITS);
    assign scl_y   = prod_reg + (64'(top_reg) <<< FRAC_BITS);

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (t2_v_reg) begin
            acc_reg <= (k2_reg[1:0] == 2'd0) ? ACC_W'(term) : acc_sum;
            if (k2_reg[1:0] == 2'd3) begin
                if (phase_reg) begin
                    cvec_reg[k2_reg[3:2]] <= sat32(64'(acc_sum));
                end else begin
                    vvec_reg[k2_reg[3:2]] <= sat32(64'(acc_sum));
                end
            end
        end
        if (s_acc) begin
            x_reg <= s_world_x;
            y_reg <= s_world_y;
            z_reg <= s_world_z;
        end
        k1_reg <= k_reg;
        k2_reg <= k1_reg;
    end

    assign div_start = (state_reg == ST_DRAIN) && !t1_v_reg && !t2_v_reg && phase_reg
                       && (cvec_reg[3] != '0);

    wtsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_x   (33'(cvec_reg[3]) + 33'(cvec_reg[0])),
        .num_y   (33'(cvec_reg[3]) - 33'(cvec_reg[1])),
        .den     ({cvec_reg[3][31], cvec_reg[3], 1'b0}),
        .done    (div_done),
        .q_x     (div_qx),
        .q_y     (div_qy)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            k_reg       <= '0;
            t1_v_reg    <= 1'b0;
            t2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            t1_v_reg <= rd_en;
            t2_v_reg <= t1_v_reg;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_cmd == CMD_PROJECT) begin
                        phase_reg <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'd15) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!t1_v_reg && !t2_v_reg) begin
                        if (!phase_reg) begin
                            phase_reg <= 1'b1;
                            k_reg     <= '0;
                            state_reg <= ST_ISSUE;
                        end else if (cvec_reg[3] == '0) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_SCLX;
                    end
                end
                ST_SCLX: state_reg <= ST_SCLY;
                ST_SCLY: state_reg <= ST_FIN;
                ST_FIN:  state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DRAIN) begin
            sx_reg <= '0;
            sy_reg <= '0;
            wz_reg <= 1'b1;
        end
        if (state_reg == ST_SCLY) begin
            sx_reg <= sat32(scl_x);
        end
        if (state_reg == ST_FIN) begin
            sy_reg <= sat32(scl_y);
            wz_reg <= 1'b0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_sx_reg <= sx_reg;
            m_sy_reg <= sy_reg;
            m_wz_reg <= wz_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_screen_x = m_sx_reg;
    assign m_screen_y = m_sy_reg;
    assign m_w_zero   = m_wz_reg;

endmodule

// File: sv/wtsp_chk.sv
// port-level checker for the projection unit and its bind
module wtsp_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_screen_x,
    input logic signed [31:0] m_screen_y,
    input logic               m_w_zero
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x) && $stable(m_screen_y)
        && $stable(m_w_zero))
        else $error("result beat changed while stalled");

    // zero clip w gives a zero screen point
    a_wzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero |-> m_screen_x == '0 && m_screen_y == '0)
        else $error("w_zero beat with nonzero coordinates");

    // no result in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result never follows an input beat directly
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after an input beat");

endmodule

bind world_to_screen_projection_unit wtsp_chk u_wtsp_chk (.*);

// File: tb/world_to_screen_checker.sv
// screen point predictor and result checker for the world-to-screen projection unit
`timescale 1ns / 1ps
module world_to_screen_checker import wtsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [3:0]         s_coeff_index,
    input  logic signed [31:0] s_coeff_value,
    input  logic signed [31:0] s_world_x,
    input  logic signed [31:0] s_world_y,
    input  logic signed [31:0] s_world_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_screen_x,
    input  logic signed [31:0] m_screen_y,
    input  logic               m_w_zero,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 points_pending
);

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               wz;
    } screen_pt_t;

    logic signed [63:0] view_m [16];
    logic signed [63:0] proj_m [16];
    logic signed [63:0] win_left, win_top, win_width, win_height;
    screen_pt_t         expected_points [$];

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] scaled_ratio(input logic signed [63:0] num,
                                                        input logic signed [63:0] w);
        logic signed [63:0] n;
        n = num * 64'sd65536;
        return clamp32(n / (64'sd2 * w));
    endfunction

    function automatic screen_pt_t project_point(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
        logic signed [63:0] pt [4];
        logic signed [63:0] eye [4];
        logic signed [63:0] clip [4];
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [63:0] full;
        screen_pt_t r;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        pt[3] = 64'sd1 <<< FRAC_BITS;
        for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                prod = view_m[j*4+row] * pt[j];
                acc += prod >>> FRAC_BITS;
            end
            eye[row] = clamp32(acc);
        end
        for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                prod = proj_m[j*4+row] * eye[j];
                acc += prod >>> FRAC_BITS;
            end
            clip[row] = clamp32(acc);
        end
        if (clip[3] == 0) begin
            r.sx = '0;
            r.sy = '0;
            r.wz = 1'b1;
        end else begin
            full = clamp32(scaled_ratio(clip[3] + clip[0], clip[3]) * win_width
                           + win_left * 64'sd65536);
            r.sx = full[31:0];
            full = clamp32(scaled_ratio(clip[3] - clip[1], clip[3]) * win_height
                           + win_top * 64'sd65536);
            r.sy = full[31:0];
            r.wz = 1'b0;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    assign points_pending = expected_points.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        screen_pt_t want;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                view_m[i] <= 0;
                proj_m[i] <= 0;
            end
            win_left <= 0;
            win_top <= 0;
            win_width <= 0;
            win_height <= 0;
            expected_points.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIN_LEFT:   win_left <= $signed(pwdata[15:0]);
                    REG_WIN_TOP:    win_top <= $signed(pwdata[15:0]);
                    REG_WIN_WIDTH:  win_width <= {48'd0, pwdata[15:0]};
                    REG_WIN_HEIGHT: win_height <= {48'd0, pwdata[15:0]};
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_cmd)
                    CMD_LOAD_VIEW: view_m[s_coeff_index] <= s_coeff_value;
                    CMD_LOAD_PROJ: proj_m[s_coeff_index] <= s_coeff_value;
                    CMD_PROJECT:
                        expected_points.push_back(project_point(s_world_x, s_world_y,
                                                                s_world_z));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected screen beat", m_screen_x, '0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_screen_x !== want.sx) report("screen_x", m_screen_x, want.sx);
                    if (m_screen_y !== want.sy) report("screen_y", m_screen_y, want.sy);
                    if (m_w_zero !== want.wz)
                        report("w_zero", 32'(m_w_zero), 32'(want.wz));
                end
            end
        end
    end

endmodule

// File: tb/testbench.sv
// stimulus, window setup and verdict for the world-to-screen projection unit
`timescale 1ns / 1ps
module testbench;
    import wtsp_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [3:0]         s_coeff_index;
    logic signed [31:0] s_coeff_value;
    logic signed [31:0] s_world_x;
    logic signed [31:0] s_world_y;
    logic signed [31:0] s_world_z;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_screen_x;
    logic signed [31:0] m_screen_y;
    logic               m_w_zero;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 points_pending;
    int                 beats_sent;
    bit                 calm_sender;

    world_to_screen_projection_unit DUT (.*);

    world_to_screen_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("** world_to_screen_projection_unit: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return $urandom;
            2: return 32'h00010000;
            default: return $urandom_range(0, 524288) - 262144;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return $urandom;
            default: return $urandom_range(0, 33554432) - 16777216;
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [31:0] val, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        int gap;
        gap = calm_sender ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_coeff_index <= idx;
        s_coeff_value <= val;
        s_world_x <= x;
        s_world_y <= y;
        s_world_z <= z;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (points_pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] regno, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regno, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_window(input logic [15:0] left, input logic [15:0] top,
                              input logic [15:0] width, input logic [15:0] height);
        drain_results();
        apb_write(REG_WIN_LEFT, {16'($urandom_range(0, 65535)), left});
        apb_write(REG_WIN_TOP, {16'($urandom_range(0, 65535)), top});
        apb_write(REG_WIN_WIDTH, {16'($urandom_range(0, 65535)), width});
        apb_write(REG_WIN_HEIGHT, {16'($urandom_range(0, 65535)), height});
    endtask

    task automatic load_matrix(input logic [1:0] cmd, input bit kill_w);
        logic [31:0] val;
        for (int i = 0; i < 16; i++) begin
            val = rand_coeff();
            if (kill_w && cmd == CMD_LOAD_PROJ && i[1:0] == 2'd3) val = '0;
            send_beat(cmd, i[3:0], val, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic project_some(input int n);
        repeat (n) send_beat(CMD_PROJECT, 4'($urandom), $urandom, rand_coord(), rand_coord(),
                             rand_coord());
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 200)
                                               : $urandom_range(1, 8)) @(posedge aclk);
            if (!calm_sender) begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        beats_sent = 0;
        calm_sender = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = '0;
        s_coeff_index = '0;
        s_coeff_value = '0;
        s_world_x = '0;
        s_world_y = '0;
        s_world_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero matrices after reset give zero clip w
        send_beat(CMD_PROJECT, 4'd0, '0, 32'h7fffffff, 32'h80000000, 32'h0);
        set_window(16'd0, 16'd0, 16'd640, 16'd480);
        // identity view, projection with w taken from view w
        for (int i = 0; i < 16; i++) begin
            send_beat(CMD_LOAD_VIEW, i[3:0], (i % 5 == 0) ? 32'h00010000 : 32'h0,
                      '0, '0, '0);
        end
        send_beat(CMD_LOAD_PROJ, 4'd0, 32'h00010000, '0, '0, '0);
        send_beat(CMD_LOAD_PROJ, 4'd5, 32'h00010000, '0, '0, '0);
        send_beat(CMD_LOAD_PROJ, 4'd15, 32'h00010000, '0, '0, '0);
        send_beat(2'd3, 4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_beat(CMD_PROJECT, 4'd15, 32'hffffffff, 32'h00008000, 32'hffff8000, 32'h0);
        send_beat(CMD_PROJECT, 4'd0, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_beat(CMD_PROJECT, 4'd0, '0, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_beat(CMD_LOAD_PROJ, 4'd15, 32'h80000000, '0, '0, '0);
        send_beat(CMD_PROJECT, 4'd0, '0, 32'h00010000, 32'h00010000, 32'h00010000);
        send_beat(CMD_LOAD_PROJ, 4'd15, 32'h7fffffff, '0, '0, '0);
        send_beat(CMD_PROJECT, 4'd0, '0, 32'hffffffff, 32'h1, 32'h0);

        set_window(16'h8000, 16'h7fff, 16'hffff, 16'hffff);
        project_some(4);
        set_window(16'h7fff, 16'h8000, 16'h0, 16'h1);
        project_some(4);

        while (beats_sent < 1650) begin
            if ($urandom_range(0, 3) == 0)
                set_window(16'($urandom), 16'($urandom),
                           16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)),
                           16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)));
            calm_sender = ($urandom_range(0, 4) == 0);
            load_matrix(CMD_LOAD_VIEW, 1'b0);
            load_matrix(CMD_LOAD_PROJ, $urandom_range(0, 5) == 0);
            project_some($urandom_range(10, 40));
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 2))
                    0: send_beat(2'd3, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
                    1: send_beat(2'($urandom_range(0, 1)), 4'($urandom), rand_coeff(),
                                 $urandom, $urandom, $urandom);
                    default: project_some(1);
                endcase
            end
        end
        calm_sender = 0;

        drain_results();
        if (fail_count == 0 && points_pending == 0) begin
            $display("** world_to_screen_projection_unit: PASSED **");
        end else begin
            $display("** world_to_screen_projection_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
sv/wtsp_pkg.sv
sv/wtsp_div.sv
sv/world_to_screen_projection_unit.sv
sv/wtsp_chk.sv
tb/world_to_screen_checker.sv
tb/testbench.sv
